@@ rtl/lesf_pkg.sv @@
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared types and constants of the largest empty square finder: field
// widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package lesf_pkg;

    localparam int CHAR_W   = 8;
    localparam int SIZE_W   = 13;   // grid_rows and grid_width registers
    localparam int SIDE_W   = 13;   // square side, as stored in the row store
    localparam int POS_W    = 12;   // top_row and left_col result fields
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 40;

    typedef enum logic [2:0] {
        REG_EMPTY_CHAR    = 3'd0,
        REG_OBSTACLE_CHAR = 3'd1,
        REG_FILL_CHAR     = 3'd2,
        REG_GRID_ROWS     = 3'd3,
        REG_GRID_WIDTH    = 3'd4
    } reg_idx_t;

    localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST    = 8'd46;
    localparam logic [CHAR_W-1:0] OBSTACLE_CHAR_RST = 8'd111;
    localparam logic [CHAR_W-1:0] FILL_CHAR_RST     = 8'd120;
    localparam logic [SIZE_W-1:0] GRID_SIZE_RST     = 13'd1;

endpackage

@@ rtl/largest_empty_square_finder_core.sv @@
// ----------------------------------------------------------------------------
// largest_empty_square_finder_core: maximal empty square over a streamed map.
// Results pass through the compute stage and then the output register.
// Throughput: one cell per cycle; the row store does one read and one write.
// Reset: rst_n clears control state at once; the row store has no reset.
// ----------------------------------------------------------------------------
//
// Cells arrive in row-major order. Each accepted cell reads the side of the
// cell above it from the row store (a synchronous memory with a registered
// read). In the next cycle the compute stage forms the side of the largest
// empty square ending at the cell, writes it back to the same column and
// updates the best square seen so far. Only when the map is one column wide
// can a read hit the column that the compute stage writes in the same cycle;
// that value is forwarded around the memory.
//
// Character classification, row and column counting and the drop-on-error
// flag live entirely in the accept stage, so the compute stage only needs
// the memory data and its own left and diagonal registers.
//
// The output register holds one result. The pipeline only stalls when the
// compute stage has a second result while the first has not been taken.
module largest_empty_square_finder_core #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lesf_pkg::PADDR_W-1:0]        paddr,
    input  logic [lesf_pkg::PDATA_W-1:0]        pwdata,
    output logic [lesf_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,

    // Cell stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lesf_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // [7:0] cell_char

    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [12:0] square_size, [24:13] top_row, [36:25] left_col, [39:37] zero
    output logic [lesf_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser    // [0] map_error
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int BASE_W = (CNT_W > lesf_pkg::SIZE_W) ? CNT_W : lesf_pkg::SIZE_W;
    // Wide enough for sizes, counts plus one and the limits themselves.
    localparam int LIM_W  = BASE_W + 1;

    localparam int SIDE_W = lesf_pkg::SIDE_W;
    localparam int CHAR_W = lesf_pkg::CHAR_W;
    localparam int SIZE_W = lesf_pkg::SIZE_W;
    localparam int POS_W  = lesf_pkg::POS_W;
    localparam int PAD_W  = lesf_pkg::TDATA_OUT_W - SIDE_W - 2 * POS_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0] empty_char_reg;
    logic [CHAR_W-1:0] obstacle_char_reg;
    logic [CHAR_W-1:0] fill_char_reg;
    logic [SIZE_W-1:0] grid_rows_reg;
    logic [SIZE_W-1:0] grid_width_reg;

    logic              cfg_wr;
    lesf_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = lesf_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_char_reg    <= lesf_pkg::EMPTY_CHAR_RST;
            obstacle_char_reg <= lesf_pkg::OBSTACLE_CHAR_RST;
            fill_char_reg     <= lesf_pkg::FILL_CHAR_RST;
            grid_rows_reg     <= lesf_pkg::GRID_SIZE_RST;
            grid_width_reg    <= lesf_pkg::GRID_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                lesf_pkg::REG_EMPTY_CHAR:    empty_char_reg    <= pwdata[CHAR_W-1:0];
                lesf_pkg::REG_OBSTACLE_CHAR: obstacle_char_reg <= pwdata[CHAR_W-1:0];
                lesf_pkg::REG_FILL_CHAR:     fill_char_reg     <= pwdata[CHAR_W-1:0];
                lesf_pkg::REG_GRID_ROWS:     grid_rows_reg     <= pwdata[SIZE_W-1:0];
                lesf_pkg::REG_GRID_WIDTH:    grid_width_reg    <= pwdata[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            lesf_pkg::REG_EMPTY_CHAR:    prdata = 32'(empty_char_reg);
            lesf_pkg::REG_OBSTACLE_CHAR: prdata = 32'(obstacle_char_reg);
            lesf_pkg::REG_FILL_CHAR:     prdata = 32'(fill_char_reg);
            lesf_pkg::REG_GRID_ROWS:     prdata = 32'(grid_rows_reg);
            lesf_pkg::REG_GRID_WIDTH:    prdata = 32'(grid_width_reg);
            default:                     prdata = '0;
        endcase
    end

    // Map sizes saturated to 1 .. MAX_WIDTH and 1 .. MAX_ROWS.
    logic [LIM_W-1:0] width_eff;
    logic [LIM_W-1:0] rows_eff;

    always_comb
    begin
        if (grid_width_reg == '0)
            width_eff = LIM_W'(1);
        else if (LIM_W'(grid_width_reg) > LIM_W'(MAX_WIDTH))
            width_eff = LIM_W'(MAX_WIDTH);
        else
            width_eff = LIM_W'(grid_width_reg);

        if (grid_rows_reg == '0)
            rows_eff = LIM_W'(1);
        else if (LIM_W'(grid_rows_reg) > LIM_W'(MAX_ROWS))
            rows_eff = LIM_W'(MAX_ROWS);
        else
            rows_eff = LIM_W'(grid_rows_reg);
    end

    // ------------------------------------------------------------------
    // Handshake and stall control
    // ------------------------------------------------------------------
    logic s_accept;
    logic s1_fire;
    logic stall;
    logic s1_produce;

    logic s1_valid_reg;
    logic s1_compute_reg;   // cell is classified and gets a side
    logic s1_err_reg;       // cell raises the error result
    logic s1_obst_reg;
    logic s1_drop_reg;      // map is dropped once this cell is done
    logic s1_last_col_reg;
    logic s1_last_cell_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;

    logic out_valid_reg;

    assign s1_produce    = s1_err_reg || (s1_last_cell_reg && !s1_drop_reg);
    assign stall         = s1_valid_reg && s1_produce && out_valid_reg && !m_axis_tready;
    assign s1_fire       = s1_valid_reg && !stall;
    assign s_axis_tready = !stall;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Accept stage: classification, counters, drop flag, store read
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic             dropping_reg;

    logic [CHAR_W-1:0] cell_char;
    logic              clash;
    logic              bad_char;
    logic              last_col;
    logic              last_cell;

    assign cell_char = s_axis_tdata[CHAR_W-1:0];
    assign clash     = (empty_char_reg == obstacle_char_reg)
                       || (empty_char_reg == fill_char_reg)
                       || (obstacle_char_reg == fill_char_reg);
    assign bad_char  = clash
                       || ((cell_char != empty_char_reg) && (cell_char != obstacle_char_reg));
    assign last_col  = (LIM_W'(col_count_reg) + LIM_W'(1)) >= width_eff;
    assign last_cell = last_col && ((LIM_W'(row_count_reg) + LIM_W'(1)) >= rows_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            dropping_reg  <= 1'b0;
        end
        else if (s_accept)
        begin
            if (last_cell)
            begin
                col_count_reg <= '0;
                row_count_reg <= '0;
                dropping_reg  <= 1'b0;
            end
            else
            begin
                if (last_col)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= row_count_reg + ROW_W'(1);
                end
                else
                begin
                    col_count_reg <= col_count_reg + COL_W'(1);
                end
                if (bad_char)
                    dropping_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Compute stage registers
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] side;
    logic              fwd_hit_reg;
    logic [SIDE_W-1:0] fwd_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s1_compute_reg   <= 1'b0;
            s1_err_reg       <= 1'b0;
            s1_drop_reg      <= 1'b0;
            s1_last_col_reg  <= 1'b0;
            s1_last_cell_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg     <= 1'b1;
            s1_compute_reg   <= !dropping_reg && !bad_char;
            s1_err_reg       <= !dropping_reg && bad_char;
            s1_drop_reg      <= dropping_reg || bad_char;
            s1_last_col_reg  <= last_col;
            s1_last_cell_reg <= last_cell;
        end
        else if (s1_fire)
        begin
            s1_valid_reg     <= 1'b0;
            s1_compute_reg   <= 1'b0;
            s1_err_reg       <= 1'b0;
            s1_drop_reg      <= 1'b0;
            s1_last_col_reg  <= 1'b0;
            s1_last_cell_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_obst_reg  <= (cell_char == obstacle_char_reg);
            s1_row_reg   <= row_count_reg;
            s1_col_reg   <= col_count_reg;
            // The compute stage always fires on an accept edge, so when its write
            // lands in the column being read now, take the new value instead.
            fwd_hit_reg  <= s1_valid_reg && s1_compute_reg && (s1_col_reg == col_count_reg);
            fwd_side_reg <= side;
        end
    end

    // ------------------------------------------------------------------
    // Row store: one write port (compute stage), one read port (accept)
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] row_mem [MAX_WIDTH];
    logic [SIDE_W-1:0] rd_side_reg;
    logic              mem_we;

    assign mem_we = s1_fire && s1_compute_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[s1_col_reg] <= side;
        if (s_accept)
            rd_side_reg <= row_mem[col_count_reg];
    end

    // ------------------------------------------------------------------
    // Compute stage logic: side, best square
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] left_side_reg;
    logic [SIDE_W-1:0] diag_side_reg;
    logic [SIDE_W-1:0] best_side_reg;
    logic [ROW_W-1:0]  best_top_reg;
    logic [COL_W-1:0]  best_left_reg;

    logic [SIDE_W-1:0] up_side;
    logic [SIDE_W-1:0] min_ul;
    logic [SIDE_W-1:0] min_all;
    logic [LIM_W-1:0]  row_p1;
    logic [LIM_W-1:0]  col_p1;
    logic              improve;
    logic [SIDE_W-1:0] best_side_next;
    logic [ROW_W-1:0]  best_top_next;
    logic [COL_W-1:0]  best_left_next;

    always_comb
    begin
        if (s1_row_reg == '0)
            up_side = '0;
        else if (fwd_hit_reg)
            up_side = fwd_side_reg;
        else
            up_side = rd_side_reg;

        min_ul  = (left_side_reg < up_side) ? left_side_reg : up_side;
        min_all = (diag_side_reg < min_ul) ? diag_side_reg : min_ul;

        if (s1_obst_reg)
            side = '0;
        else if ((s1_row_reg == '0) || (s1_col_reg == '0))
            side = SIDE_W'(1);
        else
            side = min_all + SIDE_W'(1);

        row_p1  = LIM_W'(s1_row_reg) + LIM_W'(1);
        col_p1  = LIM_W'(s1_col_reg) + LIM_W'(1);
        improve = s1_compute_reg && (side > best_side_reg)
                  && (LIM_W'(side) <= row_p1) && (LIM_W'(side) <= col_p1);

        best_side_next = best_side_reg;
        best_top_next  = best_top_reg;
        best_left_next = best_left_reg;
        if (improve)
        begin
            best_side_next = side;
            best_top_next  = ROW_W'(row_p1 - LIM_W'(side));
            best_left_next = COL_W'(col_p1 - LIM_W'(side));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_side_reg <= '0;
            diag_side_reg <= '0;
            best_side_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_last_col_reg)
            begin
                left_side_reg <= '0;
                diag_side_reg <= '0;
            end
            else if (s1_compute_reg)
            begin
                left_side_reg <= side;
                diag_side_reg <= up_side;
            end

            if (s1_last_cell_reg)
            begin
                best_side_reg <= '0;
                best_top_reg  <= '0;
                best_left_reg <= '0;
            end
            else
            begin
                best_side_reg <= best_side_next;
                best_top_reg  <= best_top_next;
                best_left_reg <= best_left_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] out_size_reg;
    logic [POS_W-1:0]  out_top_reg;
    logic [POS_W-1:0]  out_left_reg;
    logic              out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_produce)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_produce)
        begin
            if (s1_err_reg)
            begin
                out_size_reg <= '0;
                out_top_reg  <= '0;
                out_left_reg <= '0;
                out_err_reg  <= 1'b1;
            end
            else
            begin
                out_size_reg <= best_side_next;
                out_top_reg  <= POS_W'(best_top_next);
                out_left_reg <= POS_W'(best_left_next);
                out_err_reg  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_left_reg, out_top_reg, out_size_reg};
    assign m_axis_tuser  = out_err_reg;

`ifndef SYNTHESIS
    // An error result carries no square.
    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero square fields");

    // The same column is read and written in one cycle only across a row
    // boundary, which means the map is one column wide.
    a_fwd_only_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s1_valid_reg && s1_compute_reg && (s1_col_reg == col_count_reg))
        |-> s1_last_col_reg)
        else $error("row store read collides with write inside a row");

    // A second result never overwrites one that has not been taken.
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && s1_valid_reg && s1_produce) |=> $stable(m_axis_tdata))
        else $error("pending result overwritten");

    // A reported square always starts inside the map.
    a_square_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && improve) |-> (LIM_W'(side) <= row_p1) && (LIM_W'(side) <= col_p1))
        else $error("best square reaches outside the map");
`endif

endmodule
